@@ rtl/core/mssf_pkg.sv @@
// Shared types and constants for the multichannel scan sample filter.
package mssf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;

    // Filter mode codes (the unused code passes the raw sample)
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_MEAN   = 2'd1;
    localparam logic [1:0] MODE_MEDIAN = 2'd2;

    // Port and field widths
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int MODE_W         = 2;
    localparam int WLEN_W         = 3;
    localparam int SAMPLE_FIELD_W = 16;
    localparam int S_TDATA_W      = 16;
    localparam int S_TUSER_W      = 1;
    localparam int CH_FIELD_W     = 3;
    localparam int VALUE_FIELD_W  = 20;
    localparam int SEL_FIELD_W    = 3;
    localparam int M_TDATA_W      = 32;
    localparam int M_PAD_W        = M_TDATA_W - CH_FIELD_W - VALUE_FIELD_W - SEL_FIELD_W;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MLOAD,
        ST_MCMP,
        ST_DONE
    } mssf_state_t;

endpackage

@@ rtl/core/multichannel_scan_sample_filter.sv @@
// Top level of the multichannel scan sample filter: sequencer, shared arithmetic and ports.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  s_axis  | in        | s_tvalid/s_tready   | s_tdata raw_sample, s_tuser conversion_ok
//  m_axis  | out       | m_tvalid/m_tready   | m_tdata channel, value, next select
//
// A failed conversion is only accepted and gives no result; a raw result is accepted, then loaded.
// Mean reads the W words of the ring, then runs 23 steps of the bit-serial divider.
// Median reads the W words of the ring, then makes P <= W candidate passes of the comparator.
// W is the effective window. Reset clears the written flags of the history at once.
// The input is not ready while an item is in work; a result waiting in the output
// register stalls only the load of the next result, not the next transaction.
module multichannel_scan_sample_filter
    import mssf_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_WINDOW   = 7,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] raw_sample
    input  logic [S_TUSER_W-1:0]   s_tuser,   // [0] conversion_ok
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [2:0] channel_index, [22:3] filtered_value,
                                              // [25:23] next_select
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH  = NUM_CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = SAMPLE_BITS + WIN_W;
    localparam int DVD_W  = SUM_W + 4;
    localparam int VAL_W  = SAMPLE_BITS + 4;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    mssf_state_t state_reg, state_next;

    logic [MODE_W-1:0]      mode_reg;
    logic [WLEN_W-1:0]      wlen_reg;
    logic [CH_W-1:0]        scan_reg;
    logic [WIN_W-1:0]       slot_reg [NUM_CHANNELS];

    logic [CH_W-1:0]        ch_reg;
    logic [CH_W-1:0]        nsel_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [VAL_W-1:0]       res_reg;

    logic [WIN_W-1:0]       rd_cnt_reg;
    logic                   cap_en_reg;
    logic [IDX_W-1:0]       cap_idx_reg;
    logic [SAMPLE_BITS-1:0] win_buf_reg [MAX_WINDOW];
    logic [SUM_W-1:0]       sum_reg;

    logic [DVD_W-1:0]       dq_reg;
    logic [WIN_W-1:0]       rem_reg;
    logic [DCNT_W-1:0]      dcnt_reg;

    logic [SAMPLE_BITS-1:0] cand_reg;
    logic [WIN_W-1:0]       i_reg;
    logic [WIN_W-1:0]       j_reg;
    logic [WIN_W-1:0]       lt_reg;
    logic [WIN_W-1:0]       le_reg;

    logic                   m_tvalid_reg;
    logic [CH_FIELD_W-1:0]  out_ch_reg;
    logic [VALUE_FIELD_W-1:0] out_val_reg;
    logic [SEL_FIELD_W-1:0] out_nsel_reg;

    logic                   in_acc;
    logic                   conv_ok;
    logic [SAMPLE_BITS-1:0] sample;
    logic [WIN_W-1:0]       w_eff;
    logic [WIN_W-1:0]       k_med;
    logic [CH_W-1:0]        ch_cur;
    logic [CH_W-1:0]        ch_next;
    logic [WIN_W-1:0]       slot_cur;
    logic [WIN_W-1:0]       slot_adv;
    logic [WIN_W-1:0]       slot_new;
    logic [ADDR_W-1:0]      base_cur;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] mem_data;
    logic                   read_done;
    logic                   out_free;
    logic                   load_out;

    logic [WIN_W:0]         trial;
    logic                   div_ge;
    logic [WIN_W-1:0]       rem_n;
    logic [DVD_W-1:0]       dq_n;
    logic                   div_last;

    logic [WIN_W-1:0]       med_sel;
    logic [SAMPLE_BITS-1:0] med_word;
    logic [WIN_W-1:0]       lt_n;
    logic [WIN_W-1:0]       le_n;
    logic                   med_found;
    logic                   last_j;

    // Configuration writes are taken at any time
    assign cfg_ready = 1'b1;

    // Input fields
    assign in_acc  = s_tvalid && s_tready;
    assign conv_ok = s_tuser[0];
    assign sample  = s_tdata[SAMPLE_BITS-1:0];

    // Clamp the window length into 1..MAX_WINDOW
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (wlen_reg > WLEN_W'(MAX_WINDOW))
        begin
            w_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WIN_W'(wlen_reg);
        end
    end

    assign k_med = w_eff >> 1;

    // Channel and ring slot of the current transaction
    assign ch_cur   = (32'(scan_reg) >= NUM_CHANNELS) ? '0 : scan_reg;
    assign ch_next  = (ch_cur == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch_cur + CH_W'(1);
    assign slot_cur = (32'(slot_reg[ch_cur]) >= MAX_WINDOW) ? '0 : slot_reg[ch_cur];
    assign slot_adv = slot_cur + WIN_W'(1);
    assign slot_new = (slot_adv >= w_eff) ? '0 : slot_adv;
    assign base_cur = ADDR_W'(32'(ch_cur) * MAX_WINDOW);
    assign wr_addr  = base_cur + ADDR_W'(slot_cur);

    // Ring read sequence finishes once every issued read has been captured
    assign read_done = (rd_cnt_reg == w_eff) && !cap_en_reg;

    // Bit-serial restoring divider step
    assign trial    = {rem_reg, dq_reg[DVD_W-1]};
    assign div_ge   = trial >= {1'b0, w_eff};
    assign rem_n    = div_ge ? WIN_W'(trial - {1'b0, w_eff}) : WIN_W'(trial);
    assign dq_n     = {dq_reg[DVD_W-2:0], div_ge};
    assign div_last = dcnt_reg == DCNT_W'(DVD_W - 1);

    // Rank comparator for the median search
    assign med_sel   = (state_reg == ST_MLOAD) ? i_reg : j_reg;
    assign med_word  = win_buf_reg[med_sel[IDX_W-1:0]];
    assign lt_n      = lt_reg + WIN_W'(med_word < cand_reg);
    assign le_n      = le_reg + WIN_W'(med_word <= cand_reg);
    assign med_found = (lt_n <= k_med) && (le_n > k_med);
    assign last_j    = j_reg == (w_eff - WIN_W'(1));

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && conv_ok)
                begin
                    if (mode_reg == MODE_MEAN || mode_reg == MODE_MEDIAN)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                if (read_done)
                begin
                    state_next = (mode_reg == MODE_MEAN) ? ST_DIV : ST_MLOAD;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MLOAD:
            begin
                state_next = ST_MCMP;
            end
            ST_MCMP:
            begin
                if (last_j)
                begin
                    state_next = med_found ? ST_DONE : ST_MLOAD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        wr_en    = in_acc && conv_ok;
        rd_en    = (state_reg == ST_READ) && (rd_cnt_reg < w_eff);
        rd_addr  = base_reg + ADDR_W'(rd_cnt_reg);
        load_out = (state_reg == ST_DONE) && out_free;
    end

    // History rings of all channels
    mssf_hist_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_data)
    );

    // Control state: registers, scan position, slots, sequencer counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_RAW;
            wlen_reg     <= WLEN_W'(1);
            scan_reg     <= '0;
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                slot_reg[n] <= '0;
            end
            rd_cnt_reg   <= '0;
            cap_en_reg   <= 1'b0;
            dcnt_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FILTER_MODE:   mode_reg <= cfg_data[MODE_W-1:0];
                    CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[WLEN_W-1:0];
                    default:           ;
                endcase
            end

            // Advance the scan on every transaction; move the slot on a good one
            if (in_acc)
            begin
                scan_reg <= ch_next;
                if (conv_ok)
                begin
                    slot_reg[ch_cur] <= slot_new;
                end
                rd_cnt_reg <= '0;
                cap_en_reg <= 1'b0;
            end

            // Issue ring reads
            if (state_reg == ST_READ)
            begin
                cap_en_reg <= rd_en;
                if (rd_en)
                begin
                    rd_cnt_reg <= rd_cnt_reg + WIN_W'(1);
                end
                if (read_done)
                begin
                    dcnt_reg <= '0;
                    i_reg    <= '0;
                end
            end

            // Step the divider
            if (state_reg == ST_DIV)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end

            // Walk the median comparisons
            if (state_reg == ST_MLOAD)
            begin
                j_reg <= '0;
            end
            if (state_reg == ST_MCMP)
            begin
                j_reg <= j_reg + WIN_W'(1);
                if (last_j)
                begin
                    i_reg <= i_reg + WIN_W'(1);
                end
            end

            // Hold the result until the downstream transaction completes
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ch_reg   <= ch_cur;
            nsel_reg <= ch_next;
            base_reg <= base_cur;
            res_reg  <= VAL_W'({sample, 4'b0000});
            sum_reg  <= '0;
        end

        // Capture ring words and accumulate
        if (cap_en_reg)
        begin
            win_buf_reg[cap_idx_reg] <= mem_data;
            sum_reg                  <= sum_reg + SUM_W'(mem_data);
        end
        if (rd_en)
        begin
            cap_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        end

        // Load the divider with sum times sixteen
        if (state_reg == ST_READ && read_done)
        begin
            dq_reg  <= {sum_reg, 4'b0000};
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            dq_reg  <= dq_n;
            rem_reg <= rem_n;
            if (div_last)
            begin
                res_reg <= dq_n[VAL_W-1:0];
            end
        end

        // Median candidate load and rank counts
        if (state_reg == ST_MLOAD)
        begin
            cand_reg <= med_word;
            lt_reg   <= '0;
            le_reg   <= '0;
        end
        if (state_reg == ST_MCMP)
        begin
            lt_reg <= lt_n;
            le_reg <= le_n;
            if (last_j && med_found)
            begin
                res_reg <= VAL_W'({cand_reg, 4'b0000});
            end
        end

        // Output payload
        if (load_out)
        begin
            out_ch_reg   <= CH_FIELD_W'(ch_reg);
            out_val_reg  <= VALUE_FIELD_W'(res_reg);
            out_nsel_reg <= SEL_FIELD_W'(nsel_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_nsel_reg, out_val_reg, out_ch_reg};

    // Scan position never leaves the channel range
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_reg) < NUM_CHANNELS)
        else $error("scan channel out of range");

    // A result appears only from the load step of the sequencer
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the load step");

    // Divider remainder stays below the window
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < w_eff))
        else $error("divider remainder not below window");

    // Median search finds its element before running out of candidates
    a_med_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MCMP || state_reg == ST_MLOAD) |-> (i_reg < w_eff))
        else $error("median search ran past the window");

endmodule

@@ rtl/core/mssf_hist_mem.sv @@
// History sample memory with per-entry written flags; unwritten entries read as zero.
module mssf_hist_mem #(
    parameter int DEPTH  = 56,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [DATA_W-1:0] rd_q_reg;
    logic              rd_hit_reg;

    // Track which entries have been written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_addr];
            end
        end
    end

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_q_reg : '0;

endmodule

@@ tb/sv/multichannel_scan_sample_filter_test.sv @@
// Self-checking testbench for the multichannel scan sample filter: stream driver, monitor, predictor.
module multichannel_scan_sample_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mssf_pkg::*;

    localparam int CHANNELS      = 8;
    localparam int WINDOW_MAX    = 7;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASES        = 13;
    localparam int PHASE_ITEMS   = 110;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]    channel;
        logic [VALUE_FIELD_W-1:0] level;
        logic [SEL_FIELD_W-1:0]   select;
    } filtered_t;

    typedef struct {
        logic [SAMPLE_FIELD_W-1:0] sample;
        logic                      ok;
    } conversion_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [15:0] raw_sample
    logic [S_TUSER_W-1:0]   s_tuser   = '0;   // [0] conversion_ok
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // [2:0] channel_index, [22:3] filtered_value,
                                              // [25:23] next_select

    // Predictor state: a mirror of the block's registers and history
    logic [MODE_W-1:0]         mode_q;
    logic [WLEN_W-1:0]         wlen_q;
    logic [2:0]                chan_q;
    logic [SAMPLE_FIELD_W-1:0] hist [CHANNELS][WINDOW_MAX];
    logic [2:0]                slot_q [CHANNELS];

    conversion_t conversion_queue[$];
    filtered_t   filtered_due[$];
    conversion_t next_conv;
    filtered_t   want;
    filtered_t   got;

    int          errors      = 0;
    int          stall_count = 0;
    bit          calm        = 1'b0;
    logic [15:0] level_base  = '0;

    multichannel_scan_sample_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the scan and compute the filtered level of one accepted conversion
    task automatic apply_conversion(input logic [15:0] sample, input logic ok);
        int          w;
        int          ch;
        int          nxt;
        int          s;
        int          k;
        int          m;
        int unsigned sum;
        int unsigned lvl;
        logic [15:0] sorted [WINDOW_MAX];
        logic [15:0] v;
        filtered_t   r;
        ch = (chan_q >= CHANNELS) ? 0 : int'(chan_q);
        nxt = (ch + 1) % CHANNELS;
        chan_q = nxt[2:0];
        if (ok)
        begin
            w = (wlen_q == 0) ? 1 : ((wlen_q > WINDOW_MAX) ? WINDOW_MAX : int'(wlen_q));
            s = (slot_q[ch] >= WINDOW_MAX) ? 0 : int'(slot_q[ch]);
            hist[ch][s] = sample;
            s++;
            if (s >= w)
                s = 0;
            slot_q[ch] = s[2:0];
            case (mode_q)
                MODE_MEAN:
                begin
                    sum = 0;
                    for (k = 0; k < w; k++)
                        sum += int'(hist[ch][k]);
                    lvl = (sum * 16) / w;
                end
                MODE_MEDIAN:
                begin
                    for (k = 0; k < w; k++)
                        sorted[k] = hist[ch][k];
                    // insertion sort, then take the upper median
                    for (m = 1; m < w; m++)
                    begin
                        v = sorted[m];
                        k = m;
                        while (k > 0 && sorted[k - 1] > v)
                        begin
                            sorted[k] = sorted[k - 1];
                            k--;
                        end
                        sorted[k] = v;
                    end
                    lvl = int'(sorted[w / 2]) * 16;
                end
                default:
                    lvl = int'(sample) * 16;
            endcase
            r.channel = ch[2:0];
            r.level   = lvl[19:0];
            r.select  = nxt[2:0];
            filtered_due.push_back(r);
        end
    endtask

    // Input driver: present queued conversions, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_conversion(s_tdata, s_tuser[0]);
            if (!s_tvalid || s_tready)
            begin
                if (conversion_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    next_conv = conversion_queue.pop_front();
                    s_tdata  <= next_conv.sample;
                    s_tuser  <= next_conv.ok;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transaction with the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.channel = m_tdata[2:0];
                got.level   = m_tdata[22:3];
                got.select  = m_tdata[25:23];
                if (filtered_due.size() == 0)
                begin
                    $display("%0t: unexpected result ch=%0d level=%0d sel=%0d",
                             $time, got.channel, got.level, got.select);
                    errors++;
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (got !== want || m_tdata[31:26] !== '0)
                    begin
                        $display("%0t: mismatch expected ch=%0d level=%0d sel=%0d pad=0",
                                 $time, want.channel, want.level, want.select);
                        $display("%0t:          actual   ch=%0d level=%0d sel=%0d pad=%0h",
                                 $time, got.channel, got.level, got.select, m_tdata[31:26]);
                        errors++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("[multichannel_scan_sample_filter] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_FILTER_MODE)
            mode_q = value[1:0];
        else if (idx == CFG_WINDOW_LENGTH)
            wlen_q = value[2:0];
    endtask

    task automatic add_conversion(input logic [15:0] sample, input logic ok);
        conversion_t c;
        c.sample = sample;
        c.ok     = ok;
        conversion_queue.push_back(c);
    endtask

    // Wait until every result is in, then let the block finish any silent item
    task automatic settle();
        while (conversion_queue.size() != 0 || s_tvalid || filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h0000;
        else if (r < 30)
            return 16'hFFFF;
        else if (r < 60)
            return 16'(level_base + $urandom_range(0, 15));
        else
            return 16'($urandom);
    endfunction

    initial
    begin
        logic [1:0] mode_pick;
        logic [2:0] wlen_pick;
        int         phase;
        int         n;

        // Hold the predictor at its reset state
        mode_q = MODE_RAW;
        wlen_q = 3'd1;
        chan_q = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            slot_q[c] = '0;
            for (int e = 0; e < WINDOW_MAX; e++)
                hist[c][e] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: raw pass, extremes and a failed conversion
        add_conversion(16'hFFFF, 1'b1);
        add_conversion(16'h0000, 1'b1);
        add_conversion(16'h5555, 1'b0);
        add_conversion(16'hAAAA, 1'b1);
        settle();

        // Mean over a full window while the history still holds zeros
        write_reg(CFG_FILTER_MODE, {6'b0, MODE_MEAN});
        write_reg(CFG_WINDOW_LENGTH, 8'd7);
        repeat (3) add_conversion(16'hFFFF, 1'b1);
        settle();

        // Median with a zero window, which acts as a window of one
        write_reg(CFG_FILTER_MODE, {6'b0, MODE_MEDIAN});
        write_reg(CFG_WINDOW_LENGTH, 8'd0);
        add_conversion(16'h1234, 1'b1);
        add_conversion(16'h8001, 1'b1);
        settle();

        // Median over the largest window
        write_reg(CFG_WINDOW_LENGTH, 8'hF7);
        add_conversion(16'hFFFF, 1'b1);
        add_conversion(16'h0001, 1'b1);
        add_conversion(16'hFFFF, 1'b1);
        settle();

        // Unused mode code passes the raw sample; upper data bits are dropped
        write_reg(CFG_FILTER_MODE, 8'hFF);
        write_reg(CFG_WINDOW_LENGTH, 8'hFF);
        add_conversion(16'h4321, 1'b1);
        add_conversion(16'hBCDE, 1'b0);
        settle();

        // Writes to unknown indexes are ignored
        write_reg(2'd2, 8'h00);
        write_reg(2'd3, 8'hFF);
        write_reg(CFG_FILTER_MODE, {6'b101010, MODE_MEAN});
        write_reg(CFG_WINDOW_LENGTH, 8'h05);
        add_conversion(16'h7FFF, 1'b0);
        add_conversion(16'hFFFF, 1'b1);
        add_conversion(16'h0000, 1'b1);
        settle();

        // Random phases, each with its own setting; history carries across
        for (phase = 0; phase < PHASES; phase++)
        begin
            calm = (phase == 6);
            case (phase)
                0:       begin mode_pick = MODE_MEDIAN; wlen_pick = 3'd7; end
                1:       begin mode_pick = MODE_MEAN;   wlen_pick = 3'd7; end
                2:       begin mode_pick = MODE_MEAN;   wlen_pick = 3'd1; end
                3:       begin mode_pick = MODE_MEDIAN; wlen_pick = 3'd2; end
                4:       begin mode_pick = MODE_RAW;    wlen_pick = 3'd0; end
                default:
                begin
                    mode_pick = 2'($urandom_range(0, 3));
                    wlen_pick = 3'($urandom_range(0, 7));
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(2'($urandom_range(2, 3)), 8'($urandom));
            write_reg(CFG_FILTER_MODE, {6'($urandom), mode_pick});
            write_reg(CFG_WINDOW_LENGTH, {5'($urandom), wlen_pick});
            level_base = 16'($urandom);
            for (n = 0; n < PHASE_ITEMS; n++)
                add_conversion(pick_sample(), $urandom_range(0, 99) < 85);
            settle();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("[multichannel_scan_sample_filter] OK");
        else
            $display("[multichannel_scan_sample_filter] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mssf_pkg.sv
rtl/core/mssf_hist_mem.sv
rtl/core/multichannel_scan_sample_filter.sv
tb/sv/multichannel_scan_sample_filter_test.sv
